// ----- hdl/rsfe_pkg.sv -----
// shared constants, codes and types of the serial frame extractor
package rsfe_pkg;

   // buffer sizes
   localparam int WINDOW_DEPTH   = 1024;
   localparam int TRANSMIT_DEPTH = 1024;

   // derived widths: address, fill count, compare and sum widths
   localparam int WIN_AW = $clog2(WINDOW_DEPTH);
   localparam int WIN_FW = $clog2(WINDOW_DEPTH + 1);
   localparam int WIN_SW = WIN_AW + 1;
   localparam int TX_AW  = $clog2(TRANSMIT_DEPTH);
   localparam int TX_FW  = $clog2(TRANSMIT_DEPTH + 1);

   // fixed field widths
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 10;
   localparam int EV_W   = 2;
   localparam int LEN_W  = 11;
   localparam int OFF_W  = 10;
   localparam int CNT_W  = 32;

   localparam int WIN_CW = (WIN_FW > IDX_W) ? WIN_FW : IDX_W;
   localparam int TX_CW  = (TX_FW > IDX_W) ? TX_FW : IDX_W;
   localparam int ENV_CW = (WIN_FW > BYTE_W) ? WIN_FW : BYTE_W;

   // envelope: head, tail, six bytes, tail
   localparam int ENV_SPAN = 9;
   localparam int TAIL_N   = ENV_SPAN - 1;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_AW        = $clog2(QUEUE_DEPTH);
   localparam int Q_CW        = $clog2(QUEUE_DEPTH + 2);

   // command codes
   localparam logic [CMD_W-1:0] CMD_BYTE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ_WIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_TX  = 2'd2;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
   localparam logic [EV_W-1:0] EV_RX    = 2'd1;
   localparam logic [EV_W-1:0] EV_TX    = 2'd2;
   localparam logic [EV_W-1:0] EV_READ  = 2'd3;

   // read data source codes
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_WIN  = 2'd1;
   localparam logic [1:0] RD_TX   = 2'd2;

   // byte values
   localparam logic [BYTE_W-1:0] ENV_HEAD   = 8'haa;
   localparam logic [BYTE_W-1:0] ENV_TAIL   = 8'h55;
   localparam logic [BYTE_W-1:0] ESC_CHAR   = 8'h21;
   localparam logic [BYTE_W-1:0] ESC_LIT    = 8'h2e;
   localparam logic [BYTE_W-1:0] ESC_CLR_LO = 8'h63;
   localparam logic [BYTE_W-1:0] ESC_CLR_HI = 8'h43;

   // one result beat
   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [LEN_W-1:0]  packet_length;
      logic [OFF_W-1:0]  packet_offset;
      logic [BYTE_W-1:0] read_data;
      logic [CNT_W-1:0]  rx_packets;
      logic [CNT_W-1:0]  tx_packets;
   } rsp_item_type;

   // front to queue hand-off
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

endpackage

// ----- hdl/rsfe_front.sv -----
// front end: accepts beats, runs both recognizers, owns both byte stores
module rsfe_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [rsfe_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rsfe_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [rsfe_pkg::IDX_W-1:0]     req_read_index,
   output rsfe_pkg::push_type             push
);

   // byte stores
   logic [rsfe_pkg::BYTE_W-1:0] window_store_ff   [rsfe_pkg::WINDOW_DEPTH];
   logic [rsfe_pkg::BYTE_W-1:0] transmit_store_ff [rsfe_pkg::TRANSMIT_DEPTH];
   logic [rsfe_pkg::BYTE_W-1:0] win_rd_ff;
   logic [rsfe_pkg::BYTE_W-1:0] tx_rd_ff;

   // control state
   logic [rsfe_pkg::WIN_FW-1:0] win_fill_ff, win_fill_in;
   logic [rsfe_pkg::WIN_AW-1:0] win_ptr_ff, win_ptr_in;
   logic [rsfe_pkg::TX_FW-1:0]  tx_fill_ff, tx_fill_in;
   logic                        esc_ff, esc_in;
   logic [rsfe_pkg::CNT_W-1:0]  rx_cnt_ff, rx_cnt_in;
   logic [rsfe_pkg::CNT_W-1:0]  tx_cnt_ff, tx_cnt_in;
   logic [rsfe_pkg::BYTE_W-1:0] tail_ff [rsfe_pkg::TAIL_N];
   logic [rsfe_pkg::BYTE_W-1:0] tail_in [rsfe_pkg::TAIL_N];

   // stage register toward the queue
   logic                        s1_valid_ff;
   logic [rsfe_pkg::EV_W-1:0]   s1_ev_ff, s1_ev_in;
   logic [rsfe_pkg::LEN_W-1:0]  s1_len_ff, s1_len_in;
   logic [rsfe_pkg::OFF_W-1:0]  s1_off_ff, s1_off_in;
   logic [1:0]                  s1_src_ff, s1_src_in;

   // combinational helpers
   logic                        accept;
   logic                        is_byte;
   logic                        win_full;
   logic                        tx_full;
   logic                        env_hit;
   logic                        env_ok;
   logic [rsfe_pkg::ENV_CW-1:0] env_base;
   logic [rsfe_pkg::ENV_CW-1:0] env_len;
   logic                        tx_done;
   logic                        tx_we;
   logic [rsfe_pkg::BYTE_W-1:0] tx_wdata;
   logic [rsfe_pkg::WIN_AW-1:0] win_base;
   logic [rsfe_pkg::WIN_SW-1:0] win_sum;
   logic [rsfe_pkg::WIN_AW-1:0] win_ra;
   logic [rsfe_pkg::TX_AW-1:0]  tx_ra;

   assign accept   = req_valid & ~req_stall;
   assign is_byte  = accept && (req_cmd == rsfe_pkg::CMD_BYTE);
   assign win_full = (win_fill_ff == rsfe_pkg::WIN_FW'(rsfe_pkg::WINDOW_DEPTH));
   assign tx_full  = (tx_fill_ff == rsfe_pkg::TX_FW'(rsfe_pkg::TRANSMIT_DEPTH));

   // sliding window: fill, write pointer and tail of the last bytes
   always_comb begin
      win_fill_in = win_fill_ff;
      win_ptr_in  = win_ptr_ff;
      tail_in     = tail_ff;
      if (is_byte) begin
         if (!win_full) begin
            win_fill_in = win_fill_ff + 1'b1;
         end
         if (win_ptr_ff == rsfe_pkg::WIN_AW'(rsfe_pkg::WINDOW_DEPTH - 1)) begin
            win_ptr_in = '0;
         end else begin
            win_ptr_in = win_ptr_ff + 1'b1;
         end
         tail_in[0] = req_data_byte;
         for (int i = 1; i < rsfe_pkg::TAIL_N; i++) begin
            tail_in[i] = tail_ff[i-1];
         end
      end
   end

   // envelope check on the incoming byte plus the held tail
   always_comb begin
      env_hit  = (win_fill_ff >= rsfe_pkg::WIN_FW'(rsfe_pkg::TAIL_N))
               && (req_data_byte == rsfe_pkg::ENV_TAIL)
               && (tail_ff[rsfe_pkg::TAIL_N-2] == rsfe_pkg::ENV_TAIL)
               && (tail_ff[rsfe_pkg::TAIL_N-1] == rsfe_pkg::ENV_HEAD);
      env_base = rsfe_pkg::ENV_CW'(win_fill_in) - rsfe_pkg::ENV_CW'(rsfe_pkg::ENV_SPAN);
      env_len  = rsfe_pkg::ENV_CW'(tail_ff[2]);
      env_ok   = env_hit && (env_base >= env_len);
      rx_cnt_in = rx_cnt_ff + rsfe_pkg::CNT_W'(is_byte && env_ok);
   end

   // escape decoder and transmit buffer
   always_comb begin
      esc_in     = esc_ff;
      tx_fill_in = tx_fill_ff;
      tx_we      = 1'b0;
      tx_wdata   = req_data_byte;
      tx_done    = 1'b0;
      if (is_byte) begin
         if (!esc_ff) begin
            if (req_data_byte == rsfe_pkg::ESC_CHAR) begin
               esc_in = 1'b1;
            end else if (!tx_full) begin
               tx_we      = 1'b1;
               tx_fill_in = tx_fill_ff + 1'b1;
            end
         end else begin
            esc_in = 1'b0;
            if (req_data_byte == rsfe_pkg::ESC_CHAR) begin
               tx_done    = 1'b1;
               tx_fill_in = '0;
            end else if (req_data_byte == rsfe_pkg::ESC_LIT) begin
               if (!tx_full) begin
                  tx_we      = 1'b1;
                  tx_wdata   = rsfe_pkg::ESC_CHAR;
                  tx_fill_in = tx_fill_ff + 1'b1;
               end
            end else if (req_data_byte inside {rsfe_pkg::ESC_CLR_LO,
                                               rsfe_pkg::ESC_CLR_HI}) begin
               tx_fill_in = '0;
            end
         end
      end
      tx_cnt_in = tx_cnt_ff + rsfe_pkg::CNT_W'(tx_done);
   end

   // read addresses, counted from the oldest byte
   always_comb begin
      win_base = win_full ? win_ptr_ff : '0;
      win_sum  = rsfe_pkg::WIN_SW'(win_base)
               + rsfe_pkg::WIN_SW'(rsfe_pkg::WIN_CW'(req_read_index));
      if (win_sum >= rsfe_pkg::WIN_SW'(rsfe_pkg::WINDOW_DEPTH)) begin
         win_ra = rsfe_pkg::WIN_AW'(win_sum - rsfe_pkg::WIN_SW'(rsfe_pkg::WINDOW_DEPTH));
      end else begin
         win_ra = rsfe_pkg::WIN_AW'(win_sum);
      end
      tx_ra = rsfe_pkg::TX_AW'(req_read_index);
   end

   // classify the beat into its result fields
   always_comb begin
      s1_ev_in  = rsfe_pkg::EV_NONE;
      s1_len_in = '0;
      s1_off_in = '0;
      s1_src_in = rsfe_pkg::RD_NONE;
      case (req_cmd)
         rsfe_pkg::CMD_BYTE: begin
            if (env_ok) begin
               s1_ev_in  = rsfe_pkg::EV_RX;
               s1_len_in = rsfe_pkg::LEN_W'(tail_ff[2]);
               s1_off_in = rsfe_pkg::OFF_W'(env_base - env_len);
            end
            if (tx_done) begin
               s1_ev_in  = rsfe_pkg::EV_TX;
               s1_len_in = rsfe_pkg::LEN_W'(tx_fill_ff);
               s1_off_in = '0;
            end
         end
         rsfe_pkg::CMD_READ_WIN: begin
            s1_ev_in = rsfe_pkg::EV_READ;
            if (rsfe_pkg::WIN_CW'(req_read_index) < rsfe_pkg::WIN_CW'(win_fill_ff)) begin
               s1_src_in = rsfe_pkg::RD_WIN;
            end
         end
         rsfe_pkg::CMD_READ_TX: begin
            s1_ev_in = rsfe_pkg::EV_READ;
            if (rsfe_pkg::TX_CW'(req_read_index) < rsfe_pkg::TX_CW'(tx_fill_ff)) begin
               s1_src_in = rsfe_pkg::RD_TX;
            end
         end
         default: begin
            s1_ev_in = rsfe_pkg::EV_NONE;
         end
      endcase
   end

   // window store: one write, one registered read
   always_ff @(posedge clock) begin
      if (is_byte) begin
         window_store_ff[win_ptr_ff] <= req_data_byte;
      end
      win_rd_ff <= window_store_ff[win_ra];
   end

   // transmit store: one write, one registered read
   always_ff @(posedge clock) begin
      if (tx_we) begin
         transmit_store_ff[tx_fill_ff[rsfe_pkg::TX_AW-1:0]] <= tx_wdata;
      end
      tx_rd_ff <= transmit_store_ff[tx_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_fill_ff <= '0;
         win_ptr_ff  <= '0;
         tx_fill_ff  <= '0;
         esc_ff      <= 1'b0;
         rx_cnt_ff   <= '0;
         tx_cnt_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         win_fill_ff <= win_fill_in;
         win_ptr_ff  <= win_ptr_in;
         tx_fill_ff  <= tx_fill_in;
         esc_ff      <= esc_in;
         rx_cnt_ff   <= rx_cnt_in;
         tx_cnt_ff   <= tx_cnt_in;
         s1_valid_ff <= accept;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tail_ff   <= tail_in;
      s1_ev_ff  <= s1_ev_in;
      s1_len_ff <= s1_len_in;
      s1_off_ff <= s1_off_in;
      s1_src_ff <= s1_src_in;
   end

   // merge read data into the beat for the queue
   always_comb begin
      push.valid              = s1_valid_ff;
      push.item.event_res     = s1_ev_ff;
      push.item.packet_length = s1_len_ff;
      push.item.packet_offset = s1_off_ff;
      push.item.rx_packets    = rx_cnt_ff;
      push.item.tx_packets    = tx_cnt_ff;
      case (s1_src_ff)
         rsfe_pkg::RD_WIN: push.item.read_data = win_rd_ff;
         rsfe_pkg::RD_TX:  push.item.read_data = tx_rd_ff;
         default:          push.item.read_data = '0;
      endcase
   end

endmodule

// ----- hdl/rsfe_queue.sv -----
// back end: short result queue that drives the response channel
module rsfe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  rsfe_pkg::push_type     push,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rsfe_pkg::rsp_item_type rsp_item,
   output logic                   near_full
);

   rsfe_pkg::rsp_item_type entry_ff [rsfe_pkg::QUEUE_DEPTH];

   logic [rsfe_pkg::Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rsfe_pkg::Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rsfe_pkg::Q_CW-1:0] count_ff, count_in;
   logic                      pop;

   // pointer and occupancy update
   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      wr_ptr_in = wr_ptr_ff + rsfe_pkg::Q_AW'(push.valid);
      rd_ptr_in = rd_ptr_ff + rsfe_pkg::Q_AW'(pop);
      count_in  = count_ff + rsfe_pkg::Q_CW'(push.valid) - rsfe_pkg::Q_CW'(pop);
   end

   // hold off the front while the queue cannot take the beat in flight
   assign near_full = (count_ff + rsfe_pkg::Q_CW'(push.valid))
                    >= rsfe_pkg::Q_CW'(rsfe_pkg::QUEUE_DEPTH);

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ----- hdl/radio_serial_frame_extractor.sv -----
// serial frame extractor: receive envelope finder and escaped transmit framer
// an accepted beat is registered in the front stage register, then written into the queue and offered on rsp
// throughput: one beat per cycle while req_stall is low, each store takes one write and one read per cycle
// req_stall rises once queued plus in-flight beats fill the four queue entries
// reset is synchronous: fills, counters, escape flag and queue are cleared
// byte stores are not cleared; reads are gated by the fill counts
module radio_serial_frame_extractor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rsfe_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rsfe_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [rsfe_pkg::IDX_W-1:0]     req_read_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rsfe_pkg::EV_W-1:0]      rsp_event_res,
   output logic [rsfe_pkg::LEN_W-1:0]     rsp_packet_length,
   output logic [rsfe_pkg::OFF_W-1:0]     rsp_packet_offset,
   output logic [rsfe_pkg::BYTE_W-1:0]    rsp_read_data,
   output logic [rsfe_pkg::CNT_W-1:0]     rsp_rx_packets,
   output logic [rsfe_pkg::CNT_W-1:0]     rsp_tx_packets
);

   rsfe_pkg::push_type     push;
   rsfe_pkg::rsp_item_type rsp_item;
   logic                   near_full;

   assign req_stall = near_full;

   // front: recognizers and stores
   rsfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_data_byte  (req_data_byte),
      .req_read_index (req_read_index),
      .push           (push)
   );

   // back: result queue
   rsfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .near_full (near_full)
   );

   assign rsp_event_res     = rsp_item.event_res;
   assign rsp_packet_length = rsp_item.packet_length;
   assign rsp_packet_offset = rsp_item.packet_offset;
   assign rsp_read_data     = rsp_item.read_data;
   assign rsp_rx_packets    = rsp_item.rx_packets;
   assign rsp_tx_packets    = rsp_item.tx_packets;

endmodule

// ----- tb/tb_radio_serial_frame_extractor.sv -----
// testbench for the serial frame extractor: predicting scoreboard, beat drivers and checks
module tb_radio_serial_frame_extractor;
   import rsfe_pkg::*;

   // command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // predicting scoreboard: own copy of both recognizers and the expected beats
   class frame_scoreboard;
      logic [BYTE_W-1:0] win_mem [WINDOW_DEPTH];
      logic [BYTE_W-1:0] tx_mem [TRANSMIT_DEPTH];
      int unsigned       win_start;
      int unsigned       win_fill;
      int unsigned       tx_fill;
      bit                esc_pending;
      logic [CNT_W-1:0]  rx_count;
      logic [CNT_W-1:0]  tx_count;
      rsp_item_type      expected_q[$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       rx_seen;
      int unsigned       tx_seen;
      int unsigned       reads_seen;
      int unsigned       longest_tx;

      function new();
         foreach (win_mem[i]) win_mem[i] = '0;
         foreach (tx_mem[i]) tx_mem[i] = '0;
         win_start   = 0;
         win_fill    = 0;
         tx_fill     = 0;
         esc_pending = 1'b0;
         rx_count    = '0;
         tx_count    = '0;
         errors      = 0;
         checked     = 0;
         rx_seen     = 0;
         tx_seen     = 0;
         reads_seen  = 0;
         longest_tx  = 0;
      endfunction

      function logic [BYTE_W-1:0] win_at(int unsigned i);
         return win_mem[(win_start + i) % WINDOW_DEPTH];
      endfunction

      // sliding window: drop the oldest byte once full
      function void win_push(logic [BYTE_W-1:0] b);
         if (win_fill >= WINDOW_DEPTH) begin
            win_mem[win_start % WINDOW_DEPTH] = b;
            win_start = (win_start + 1) % WINDOW_DEPTH;
         end else begin
            win_mem[(win_start + win_fill) % WINDOW_DEPTH] = b;
            win_fill++;
         end
      endfunction

      function void tx_append(logic [BYTE_W-1:0] b);
         if (tx_fill < TRANSMIT_DEPTH) begin
            tx_mem[tx_fill] = b;
            tx_fill++;
         end
      endfunction

      // work out the result beat of one accepted request beat
      function void note_beat(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                              logic [IDX_W-1:0] idx);
         rsp_item_type exp_item;
         int unsigned  len;
         int unsigned  pos;
         exp_item = '0;
         len = 0;
         pos = 32'(idx);
         if (cmd == CMD_BYTE) begin
            win_push(b);
            // receive envelope: head, tail, six bytes with the length, tail
            if (win_fill >= ENV_SPAN && win_at(win_fill - 1) == ENV_TAIL &&
                win_at(win_fill - 8) == ENV_TAIL && win_at(win_fill - 9) == ENV_HEAD) begin
               len = 32'(win_at(win_fill - 4));
               if (win_fill - 9 >= len) begin
                  exp_item.event_res     = EV_RX;
                  exp_item.packet_length = LEN_W'(len);
                  exp_item.packet_offset = OFF_W'(win_fill - 9 - len);
                  rx_count++;
               end
            end
            // transmit escapes
            if (!esc_pending) begin
               if (b == ESC_CHAR) esc_pending = 1'b1;
               else tx_append(b);
            end else begin
               if (b == ESC_CHAR) begin
                  exp_item.event_res     = EV_TX;
                  exp_item.packet_length = LEN_W'(tx_fill);
                  exp_item.packet_offset = '0;
                  if (tx_fill > longest_tx) longest_tx = tx_fill;
                  tx_count++;
                  tx_fill = 0;
               end else if (b == ESC_LIT) begin
                  tx_append(ESC_CHAR);
               end else if (b == ESC_CLR_LO || b == ESC_CLR_HI) begin
                  tx_fill = 0;
               end
               esc_pending = 1'b0;
            end
         end else if (cmd == CMD_READ_WIN) begin
            exp_item.event_res = EV_READ;
            if (pos < win_fill) exp_item.read_data = win_at(pos);
         end else if (cmd == CMD_READ_TX) begin
            exp_item.event_res = EV_READ;
            if (pos < tx_fill) exp_item.read_data = tx_mem[pos];
         end
         exp_item.rx_packets = rx_count;
         exp_item.tx_packets = tx_count;
         expected_q.push_back(exp_item);
      endfunction

      // compare one result beat with the oldest expectation
      function void check_beat(rsp_item_type got);
         rsp_item_type exp_item;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result beat with nothing expected: ev %0d len %0d off %0d",
                        $realtime, got.event_res, got.packet_length, got.packet_offset);
            return;
         end
         exp_item = expected_q.pop_front();
         checked++;
         case (exp_item.event_res)
            EV_RX:   rx_seen++;
            EV_TX:   tx_seen++;
            EV_READ: reads_seen++;
            default: ;
         endcase
         if (got.event_res !== exp_item.event_res ||
             got.packet_length !== exp_item.packet_length ||
             got.packet_offset !== exp_item.packet_offset ||
             got.read_data !== exp_item.read_data ||
             got.rx_packets !== exp_item.rx_packets ||
             got.tx_packets !== exp_item.tx_packets) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch on result %0d", $realtime, checked);
               $display("  expected ev %0d len %0d off %0d data %h rx %0d tx %0d",
                        exp_item.event_res, exp_item.packet_length, exp_item.packet_offset,
                        exp_item.read_data, exp_item.rx_packets, exp_item.tx_packets);
               $display("  actual   ev %0d len %0d off %0d data %h rx %0d tx %0d",
                        got.event_res, got.packet_length, got.packet_offset,
                        got.read_data, got.rx_packets, got.tx_packets);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd        = CMD_BYTE;
   logic [BYTE_W-1:0]  req_data_byte  = '0;
   logic [IDX_W-1:0]   req_read_index = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [EV_W-1:0]    rsp_event_res;
   logic [LEN_W-1:0]   rsp_packet_length;
   logic [OFF_W-1:0]   rsp_packet_offset;
   logic [BYTE_W-1:0]  rsp_read_data;
   logic [CNT_W-1:0]   rsp_rx_packets;
   logic [CNT_W-1:0]   rsp_tx_packets;
   rsp_item_type       rsp_beat;

   bit                 steady = 1'b0;
   int unsigned        beats_sent = 0;
   frame_scoreboard    sb = new();

   radio_serial_frame_extractor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_packet_length (rsp_packet_length),
      .rsp_packet_offset (rsp_packet_offset),
      .rsp_read_data     (rsp_read_data),
      .rsp_rx_packets    (rsp_rx_packets),
      .rsp_tx_packets    (rsp_tx_packets)
   );

   assign rsp_beat = {rsp_event_res, rsp_packet_length, rsp_packet_offset,
                      rsp_read_data, rsp_rx_packets, rsp_tx_packets};

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5000000;
      $display("tb_radio_serial_frame_extractor: done, errors");
      $finish;
   end

   // result side: random stall, check every accepted beat
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 38);
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_beat);
   end

   // any byte but the escape character
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom);
      if (b == ESC_CHAR) b = b + 8'd1;
      return b;
   endfunction

   // one request beat, with random idle cycles ahead of it while steady is clear
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                            input logic [IDX_W-1:0] idx);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_data_byte  <= b;
      req_read_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beat(cmd, b, idx);
      beats_sent++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_beat(CMD_BYTE, b, IDX_W'($urandom));
   endtask

   task automatic send_read(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
      send_beat(cmd, BYTE_W'($urandom), idx);
   endtask

   // head, tail, three bytes, length, two bytes, tail
   task automatic send_envelope(input logic [BYTE_W-1:0] len);
      send_byte(ENV_HEAD);
      send_byte(ENV_TAIL);
      repeat (3) send_byte(plain_byte());
      send_byte(len);
      repeat (2) send_byte(plain_byte());
      send_byte(ENV_TAIL);
   endtask

   // hold off the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned       mixed_end;
      int unsigned       pick;
      int unsigned       room;
      int unsigned       fill;
      int unsigned       n;
      logic [BYTE_W-1:0] len;
      logic [BYTE_W-1:0] second;
      logic [CMD_W-1:0]  src;
      logic [IDX_W-1:0]  idx;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty buffers and the unused command
      send_read(CMD_READ_WIN, '0);
      send_read(CMD_READ_TX, '1);
      send_beat(CMD_UNUSED, 8'hff, '1);
      // envelope shape with too few bytes, then one whose length reaches too far back
      send_byte(ENV_HEAD);
      send_byte(ENV_TAIL);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h00);
      send_byte(8'h33);
      send_byte(8'h44);
      send_byte(ENV_TAIL);
      send_byte(ENV_TAIL);
      // proper envelope with zero length
      send_envelope(8'h00);
      // literal escape, unknown escape, read back, packet complete
      send_byte(ESC_CHAR);
      send_byte(ESC_LIT);
      send_byte(ESC_CHAR);
      send_byte(8'h00);
      send_read(CMD_READ_TX, 10'd17);
      send_byte(ESC_CHAR);
      send_byte(ESC_CHAR);
      // both clear escapes, then an empty packet
      send_byte(8'hff);
      send_byte(ESC_CHAR);
      send_byte(ESC_CLR_LO);
      send_byte(ESC_CHAR);
      send_byte(ESC_CLR_HI);
      send_byte(ESC_CHAR);
      send_byte(ESC_CHAR);

      // mixed traffic: mostly envelopes, escaped frames and reads
      mixed_end = beats_sent + 280;
      while (beats_sent < mixed_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            room = (sb.win_fill > 255) ? 255 : sb.win_fill;
            if ($urandom_range(0, 9) < 7) len = BYTE_W'($urandom_range(0, room));
            else len = BYTE_W'($urandom_range(0, 255));
            send_envelope(len);
         end else if (pick < 60) begin
            n = $urandom_range(0, 12);
            repeat (n) send_byte(plain_byte());
            case ($urandom_range(0, 4))
               0:       second = ESC_CHAR;
               1:       second = ESC_LIT;
               2:       second = ESC_CLR_LO;
               3:       second = ESC_CLR_HI;
               default: second = BYTE_W'($urandom);
            endcase
            send_byte(ESC_CHAR);
            send_byte(second);
         end else if (pick < 85) begin
            src  = $urandom_range(0, 1) ? CMD_READ_WIN : CMD_READ_TX;
            fill = (src == CMD_READ_WIN) ? sb.win_fill : sb.tx_fill;
            if (fill > 0 && $urandom_range(0, 9) < 7) idx = IDX_W'($urandom_range(0, fill - 1));
            else idx = IDX_W'($urandom);
            send_read(src, idx);
         end else if (pick < 92) begin
            send_beat(CMD_UNUSED, BYTE_W'($urandom), IDX_W'($urandom));
         end else begin
            send_byte(BYTE_W'($urandom));
         end
      end

      drain();

      // long stream without escapes, its first part with no idling on either side
      steady = 1'b1;
      for (int i = 0; i < 380; i++) begin
         if (i == 200) steady = 1'b0;
         if (i % 60 == 59) send_envelope(plain_byte());
         else if (i % 25 == 0)
            send_read($urandom_range(0, 1) ? CMD_READ_WIN : CMD_READ_TX, IDX_W'($urandom));
         else send_byte(plain_byte());
      end
      send_read(CMD_READ_TX, '1);
      send_read(CMD_READ_WIN, '1);
      send_byte(ESC_CHAR);
      send_byte(ESC_CHAR);

      drain();
      repeat (20) @(posedge clock);

      $display("sent %0d beats, checked %0d results: %0d envelopes, %0d frames, %0d reads",
               beats_sent, sb.checked, sb.rx_seen, sb.tx_seen, sb.reads_seen);
      $display("window filled to %0d bytes, longest transmit frame %0d bytes",
               sb.win_fill, sb.longest_tx);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("tb_radio_serial_frame_extractor: done, clean");
      else
         $display("tb_radio_serial_frame_extractor: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/rsfe_pkg.sv
hdl/rsfe_front.sv
hdl/rsfe_queue.sv
hdl/radio_serial_frame_extractor.sv
tb/tb_radio_serial_frame_extractor.sv
